// File: sv/tlpq_pkg.sv
// Shared types and constants for the two-class strict-priority queue.
package tlpq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_OUT_W     = 5;
  localparam int STATUS_W      = 2;

  localparam int IN_DATA_W   = ((PAYLOAD_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = ((PAYLOAD_WIDTH + 2 * CNT_OUT_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = STATUS_W + 1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic PRIO_URGENT = 1'b0;
  localparam logic PRIO_NORMAL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_SEND
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    push_urg;
    logic    push_norm;
    logic    pop_urg;
    logic    pop_norm;
    status_e status;
  } dp_cmd_t;

  // Queue status from the datapath to the controller.
  typedef struct packed {
    logic urg_empty;
    logic urg_full;
    logic norm_empty;
    logic norm_full;
  } dp_stat_t;

endpackage

// File: sv/tlpq_ctrl.sv
// Controller state machine: decodes commands and sequences the result handshake.
module tlpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               command_i,
  input  logic               priority_req_i,
  input  logic               out_ready_i,
  input  tlpq_pkg::dp_stat_t stat_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output tlpq_pkg::dp_cmd_t  cmd_o
);
  import tlpq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = (state_q == CS_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_SEND;
      end
      CS_SEND: begin
        if (out_ready_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == CS_IDLE);
    out_valid_o = (state_q == CS_SEND);
    cmd_o        = '0;
    cmd_o.status = ST_OK;
    if (accept) begin
      cmd_o.load = 1'b1;
      if (command_i == CMD_PUSH) begin
        if (priority_req_i == PRIO_URGENT) begin
          if (stat_i.urg_full) cmd_o.status = ST_FULL;
          else                 cmd_o.push_urg = 1'b1;
        end else begin
          if (stat_i.norm_full) cmd_o.status = ST_FULL;
          else                  cmd_o.push_norm = 1'b1;
        end
      end else if (!stat_i.urg_empty) begin
        cmd_o.pop_urg = 1'b1;
      end else if (!stat_i.norm_empty) begin
        cmd_o.pop_norm = 1'b1;
      end else begin
        cmd_o.status = ST_EMPTY;
      end
    end
  end

  // A result is never offered in the same cycle as a new command is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("controller offers a result while accepting input");

  // Each accepted command leads to exactly one offered result next cycle.
  a_accept_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted command did not produce a result");

  // At most one queue operation per command.
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push_urg, cmd_o.push_norm, cmd_o.pop_urg, cmd_o.pop_norm}))
    else $error("more than one queue operation issued");

endmodule

// File: sv/tlpq_datapath.sv
// Datapath: both queue memories, their pointers and fill counts, and the result register.
module tlpq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tlpq_pkg::dp_cmd_t                   cmd_i,
  input  logic [tlpq_pkg::PAYLOAD_WIDTH-1:0]  payload_i,
  output tlpq_pkg::dp_stat_t                  stat_o,
  output tlpq_pkg::status_e                   status_o,
  output logic [tlpq_pkg::PAYLOAD_WIDTH-1:0]  popped_data_o,
  output logic                                from_urgent_o,
  output logic [tlpq_pkg::CNT_OUT_W-1:0]      urgent_count_o,
  output logic [tlpq_pkg::CNT_OUT_W-1:0]      normal_count_o
);
  import tlpq_pkg::*;

  logic [PAYLOAD_WIDTH-1:0] urg_mem  [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] norm_mem [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] urg_rd_q, norm_rd_q;

  logic [PTR_W-1:0] urg_head_q, urg_head_d, urg_tail_q, urg_tail_d;
  logic [PTR_W-1:0] norm_head_q, norm_head_d, norm_tail_q, norm_tail_d;
  logic [CNT_W-1:0] urg_fill_q, urg_fill_d, norm_fill_q, norm_fill_d;

  status_e status_q;
  logic    from_urgent_q, popped_q;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat_o.urg_empty  = (urg_fill_q == '0);
  assign stat_o.urg_full   = (urg_fill_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.norm_empty = (norm_fill_q == '0);
  assign stat_o.norm_full  = (norm_fill_q == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    urg_head_d  = cmd_i.pop_urg   ? advance(urg_head_q)  : urg_head_q;
    urg_tail_d  = cmd_i.push_urg  ? advance(urg_tail_q)  : urg_tail_q;
    norm_head_d = cmd_i.pop_norm  ? advance(norm_head_q) : norm_head_q;
    norm_tail_d = cmd_i.push_norm ? advance(norm_tail_q) : norm_tail_q;
    urg_fill_d  = urg_fill_q;
    norm_fill_d = norm_fill_q;
    if (cmd_i.push_urg)  urg_fill_d  = urg_fill_q + CNT_W'(1);
    if (cmd_i.pop_urg)   urg_fill_d  = urg_fill_q - CNT_W'(1);
    if (cmd_i.push_norm) norm_fill_d = norm_fill_q + CNT_W'(1);
    if (cmd_i.pop_norm)  norm_fill_d = norm_fill_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      urg_head_q    <= '0;
      urg_tail_q    <= '0;
      urg_fill_q    <= '0;
      norm_head_q   <= '0;
      norm_tail_q   <= '0;
      norm_fill_q   <= '0;
      status_q      <= ST_OK;
      from_urgent_q <= 1'b0;
      popped_q      <= 1'b0;
    end else begin
      urg_head_q  <= urg_head_d;
      urg_tail_q  <= urg_tail_d;
      urg_fill_q  <= urg_fill_d;
      norm_head_q <= norm_head_d;
      norm_tail_q <= norm_tail_d;
      norm_fill_q <= norm_fill_d;
      if (cmd_i.load) begin
        status_q      <= cmd_i.status;
        from_urgent_q <= cmd_i.pop_urg;
        popped_q      <= cmd_i.pop_urg || cmd_i.pop_norm;
      end
    end
  end

  // Urgent queue memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_urg) urg_mem[urg_tail_q] <= payload_i;
    if (cmd_i.pop_urg)  urg_rd_q <= urg_mem[urg_head_q];
  end

  // Normal queue memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_norm) norm_mem[norm_tail_q] <= payload_i;
    if (cmd_i.pop_norm)  norm_rd_q <= norm_mem[norm_head_q];
  end

  assign status_o       = status_q;
  assign from_urgent_o  = from_urgent_q;
  assign popped_data_o  = !popped_q     ? '0 :
                          from_urgent_q ? urg_rd_q : norm_rd_q;
  assign urgent_count_o = CNT_OUT_W'(urg_fill_q);
  assign normal_count_o = CNT_OUT_W'(norm_fill_q);

  a_urg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    urg_fill_q <= CNT_W'(QUEUE_DEPTH) && norm_fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  // The normal queue is served only while the urgent queue is empty.
  a_strict_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_norm |-> stat_o.urg_empty)
    else $error("normal entry popped while urgent entries wait");

  a_urg_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_urg |=> urg_fill_q == $past(urg_fill_q) - CNT_W'(1))
    else $error("urgent fill count did not drop after a pop");

  // An empty urgent queue has matching head and tail pointers.
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (urg_fill_q == '0) |-> (urg_head_q == urg_tail_q))
    else $error("urgent pointers disagree on an empty queue");

endmodule

// File: sv/two_level_priority_queue.sv
// Top level of the two-class strict-priority queue: stream ports, controller and datapath.
//
//   Channel   Direction  Signals              Contents
//   s_axis    in         tvalid/tready/tdata  tdata: payload; tuser: command, priority_req
//   m_axis    out        tvalid/tready/tdata  tdata: popped_data, counts; tuser: status, flag
//
// A command is taken and its result is offered from the next cycle on, through the
// single result register and the registered memory read; no new command is taken until
// that result is accepted. A stalled sink holds the result and blocks
// new commands. Reset clears pointers, fill counts and the controller; the queue
// memories are not cleared.
module two_level_priority_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [PAYLOAD_WIDTH-1:0] payload, zero padding above
  input  logic [tlpq_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // [0] command, [1] priority_req
  input  logic [tlpq_pkg::IN_USER_W-1:0]       s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // popped_data, then urgent_count, then normal_count, zero padding above
  output logic [tlpq_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // [1:0] status, [2] from_urgent
  output logic [tlpq_pkg::OUT_USER_W-1:0]      m_axis_tuser_o
);
  import tlpq_pkg::*;

  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  status_e                  status;
  logic [PAYLOAD_WIDTH-1:0] popped_data;
  logic                     from_urgent;
  logic [CNT_OUT_W-1:0]     urgent_count, normal_count;

  tlpq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .command_i      (s_axis_tuser_i[0]),
    .priority_req_i (s_axis_tuser_i[1]),
    .out_ready_i    (m_axis_tready_i),
    .stat_i         (stat),
    .in_ready_o     (s_axis_tready_o),
    .out_valid_o    (m_axis_tvalid_o),
    .cmd_o          (cmd)
  );

  tlpq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .payload_i      (s_axis_tdata_i[PAYLOAD_WIDTH-1:0]),
    .stat_o         (stat),
    .status_o       (status),
    .popped_data_o  (popped_data),
    .from_urgent_o  (from_urgent),
    .urgent_count_o (urgent_count),
    .normal_count_o (normal_count)
  );

  assign m_axis_tdata_o = OUT_DATA_W'({normal_count, urgent_count, popped_data});
  assign m_axis_tuser_o = {from_urgent, status};

endmodule

// File: sim/two_level_priority_queue_tb.sv
// Self-checking testbench for the two-class strict-priority queue with a scoreboard.
module two_level_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT    = 22;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_FIRST = 200;
  localparam int QUIET_LAST  = 290;

  typedef struct packed {
    status_e                  status;
    logic [PAYLOAD_WIDTH-1:0] data;
    logic                     urgent;
    logic [CNT_OUT_W-1:0]     urg_cnt;
    logic [CNT_OUT_W-1:0]     norm_cnt;
  } queue_result_t;

  class queue_scoreboard;
    logic [PAYLOAD_WIDTH-1:0] urg_mem [QUEUE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] norm_mem [QUEUE_DEPTH];
    int unsigned urg_head, urg_tail, urg_fill;
    int unsigned norm_head, norm_tail, norm_fill;
    queue_result_t pending_results[$];
    int errors;
    int checked;

    function new();
      urg_head = 0;
      urg_tail = 0;
      urg_fill = 0;
      norm_head = 0;
      norm_tail = 0;
      norm_fill = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned wrap_next(int unsigned ptr);
      return (ptr == QUEUE_DEPTH - 1) ? 0 : ptr + 1;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Works out the result of one accepted command and updates the queue state.
    function void take_command(logic cmd, logic prio, logic [PAYLOAD_WIDTH-1:0] payload);
      queue_result_t r;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_PUSH) begin
        if (prio == PRIO_URGENT) begin
          if (urg_fill >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            urg_mem[urg_tail] = payload;
            urg_tail = wrap_next(urg_tail);
            urg_fill++;
          end
        end else begin
          if (norm_fill >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            norm_mem[norm_tail] = payload;
            norm_tail = wrap_next(norm_tail);
            norm_fill++;
          end
        end
      end else if (urg_fill != 0) begin
        r.data = urg_mem[urg_head];
        r.urgent = 1'b1;
        urg_head = wrap_next(urg_head);
        urg_fill--;
      end else if (norm_fill != 0) begin
        r.data = norm_mem[norm_head];
        norm_head = wrap_next(norm_head);
        norm_fill--;
      end else begin
        r.status = ST_EMPTY;
      end
      r.urg_cnt = urg_fill[CNT_OUT_W-1:0];
      r.norm_cnt = norm_fill[CNT_OUT_W-1:0];
      pending_results.push_back(r);
    endfunction

    task check_result(queue_result_t got);
      queue_result_t exp;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with no command outstanding", checked));
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status)
          report($sformatf("result %0d: status %0d, expected %0d", checked, got.status,
                           exp.status));
        if (got.data !== exp.data)
          report($sformatf("result %0d: popped_data %0h, expected %0h", checked, got.data,
                           exp.data));
        if (got.urgent !== exp.urgent)
          report($sformatf("result %0d: from_urgent %0b, expected %0b", checked, got.urgent,
                           exp.urgent));
        if (got.urg_cnt !== exp.urg_cnt)
          report($sformatf("result %0d: urgent_count %0d, expected %0d", checked,
                           got.urg_cnt, exp.urg_cnt));
        if (got.norm_cnt !== exp.norm_cnt)
          report($sformatf("result %0d: normal_count %0d, expected %0d", checked,
                           got.norm_cnt, exp.norm_cnt));
      end
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // [PAYLOAD_WIDTH-1:0] payload, zero padding above
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  // [0] command, [1] priority_req
  logic [IN_USER_W-1:0]  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // popped_data, then urgent_count, then normal_count, zero padding above
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // [1:0] status, [2] from_urgent
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  queue_scoreboard sb = new();
  logic quiet;
  int   stall_cycles = 0;

  two_level_priority_queue uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Result side: random back-pressure, none inside the quiet stretch.
  always @(negedge clk_i) begin
    m_axis_tready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    queue_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status   = status_e'(m_axis_tuser_o[STATUS_W-1:0]);
      got.urgent   = m_axis_tuser_o[STATUS_W];
      got.data     = m_axis_tdata_o[PAYLOAD_WIDTH-1:0];
      got.urg_cnt  = m_axis_tdata_o[PAYLOAD_WIDTH +: CNT_OUT_W];
      got.norm_cnt = m_axis_tdata_o[PAYLOAD_WIDTH + CNT_OUT_W +: CNT_OUT_W];
      sb.check_result(got);
    end
  end

  // Ends the run if no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task send_command(logic cmd, logic prio, logic [PAYLOAD_WIDTH-1:0] payload);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'(payload);
    s_axis_tuser_i  <= {prio, cmd};
    do
      @(posedge clk_i);
    while (!s_axis_tready_o);
    sb.take_command(cmd, prio, payload);
  endtask

  task random_payload(output logic [PAYLOAD_WIDTH-1:0] payload);
    case ($urandom_range(0, 9))
      0:       payload = '0;
      1:       payload = '1;
      default: payload = $urandom;
    endcase
  endtask

  initial begin
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic cmd, prio;
    int push_pct, urg_pct;
    quiet = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pops, extreme payloads, urgent before an older normal entry.
    send_command(CMD_POP, PRIO_URGENT, '0);
    send_command(CMD_POP, PRIO_NORMAL, '1);
    send_command(CMD_PUSH, PRIO_URGENT, '0);
    send_command(CMD_PUSH, PRIO_URGENT, '1);
    send_command(CMD_PUSH, PRIO_NORMAL, 32'hAAAA_5555);
    send_command(CMD_PUSH, PRIO_NORMAL, 32'h5555_AAAA);
    send_command(CMD_POP, PRIO_URGENT, '0);
    send_command(CMD_POP, PRIO_NORMAL, '0);
    send_command(CMD_POP, PRIO_URGENT, '0);
    send_command(CMD_POP, PRIO_URGENT, '0);
    send_command(CMD_POP, PRIO_URGENT, '0);
    send_command(CMD_PUSH, PRIO_NORMAL, 32'h0000_0001);
    send_command(CMD_PUSH, PRIO_URGENT, 32'h8000_0000);
    send_command(CMD_POP, PRIO_NORMAL, '0);
    send_command(CMD_POP, PRIO_NORMAL, '0);
    send_command(CMD_POP, PRIO_NORMAL, '0);

    // Random blocks alternate between filling, draining and a mix, with a
    // per-block lean toward one queue so that each queue runs full and empty.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 45 == 0) begin
        case ((i / 45) % 3)
          0:       push_pct = 85;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       urg_pct = 10;
          1:       urg_pct = 90;
          default: urg_pct = 50;
        endcase
      end
      quiet = (i >= QUIET_FIRST) && (i < QUIET_LAST);
      cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      prio = ($urandom_range(0, 99) < urg_pct) ? PRIO_URGENT : PRIO_NORMAL;
      random_payload(payload);
      send_command(cmd, prio, payload);
    end
    quiet = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
